// ===== hw/rtl/bfa_pkg.sv =====
// Shared constants, types and arithmetic helpers of the box free area block.
package bfa_pkg;

    localparam int COORD_BITS    = 16;
    localparam int ID_BITS       = 20;
    localparam int AREA_BITS     = 32;
    localparam int PROD_BITS     = (2 * COORD_BITS > AREA_BITS) ? 2 * COORD_BITS : AREA_BITS;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;

    localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AREA_BITS-1:0]  area_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_BOX_LEFT   = 2'd0,
        REG_BOX_BOTTOM = 2'd1,
        REG_BOX_RIGHT  = 2'd2,
        REG_BOX_TOP    = 2'd3
    } reg_idx_t;

    // Box corners plus the box area, kept ready for list restarts.
    typedef struct packed {
        coord_t left;
        coord_t bottom;
        coord_t right;
        coord_t top;
        area_t  area;
    } box_t;

    typedef struct packed {
        logic               start_list;
        logic [ID_BITS-1:0] blockage_id;
        coord_t             rect_llx;
        coord_t             rect_lly;
        coord_t             rect_urx;
        coord_t             rect_ury;
    } req_t;

    typedef struct packed {
        logic  overlaps_box;
        area_t isect_area;
    } ovl_t;

    function automatic coord_t span(input coord_t lo, input coord_t hi);
        span = (hi > lo) ? coord_t'(hi - lo) : '0;
    endfunction

    function automatic area_t area_sat(input coord_t w, input coord_t h);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(w) * PROD_BITS'(h);
        area_sat = (prod > PROD_BITS'(AREA_MAX)) ? AREA_MAX : prod[AREA_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/bfa_req_if.sv =====
// Request channel carrying one blockage rectangle per handshake.
interface bfa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        start_list;
    logic [bfa_pkg::ID_BITS-1:0] blockage_id;
    bfa_pkg::coord_t             rect_llx;
    bfa_pkg::coord_t             rect_lly;
    bfa_pkg::coord_t             rect_urx;
    bfa_pkg::coord_t             rect_ury;

    modport source (
        output valid, start_list, blockage_id, rect_llx, rect_lly, rect_urx, rect_ury,
        input  ready
    );
    modport sink (
        input  valid, start_list, blockage_id, rect_llx, rect_lly, rect_urx, rect_ury,
        output ready
    );
endinterface

// ===== hw/rtl/bfa_rsp_if.sv =====
// Result channel carrying the overlap and free area of one blockage.
interface bfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        overlaps_box;
    logic [bfa_pkg::ID_BITS-1:0] blockage_id_out;
    bfa_pkg::area_t              isect_area;
    bfa_pkg::area_t              free_area;

    modport source (
        output valid, overlaps_box, blockage_id_out, isect_area, free_area,
        input  ready
    );
    modport sink (
        input  valid, overlaps_box, blockage_id_out, isect_area, free_area,
        output ready
    );
endinterface

// ===== hw/rtl/bfa_cfg_regs.sv =====
// APB register file holding the box corners and the derived box area.
module bfa_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bfa_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [bfa_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [bfa_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output bfa_pkg::box_t                      box
);

    bfa_pkg::coord_t   left_reg, bottom_reg, right_reg, top_reg;
    bfa_pkg::area_t    box_area;
    bfa_pkg::reg_idx_t idx;
    logic              wr_en;
    bfa_pkg::coord_t   wr_val;

    assign pready = 1'b1;
    assign idx    = bfa_pkg::reg_idx_t'(paddr[bfa_pkg::CFG_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_val = pwdata[bfa_pkg::COORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            bottom_reg <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                bfa_pkg::REG_BOX_LEFT:   left_reg   <= wr_val;
                bfa_pkg::REG_BOX_BOTTOM: bottom_reg <= wr_val;
                bfa_pkg::REG_BOX_RIGHT:  right_reg  <= wr_val;
                bfa_pkg::REG_BOX_TOP:    top_reg    <= wr_val;
                default: ;
            endcase
        end
    end

    // The box area is derived from the corners without delay.
    assign box_area = bfa_pkg::area_sat(bfa_pkg::span(left_reg, right_reg),
                                        bfa_pkg::span(bottom_reg, top_reg));

    always_comb
    begin
        case (idx)
            bfa_pkg::REG_BOX_LEFT:   prdata = bfa_pkg::CFG_DATA_BITS'(left_reg);
            bfa_pkg::REG_BOX_BOTTOM: prdata = bfa_pkg::CFG_DATA_BITS'(bottom_reg);
            bfa_pkg::REG_BOX_RIGHT:  prdata = bfa_pkg::CFG_DATA_BITS'(right_reg);
            bfa_pkg::REG_BOX_TOP:    prdata = bfa_pkg::CFG_DATA_BITS'(top_reg);
            default:                 prdata = '0;
        endcase
    end

    assign box.left   = left_reg;
    assign box.bottom = bottom_reg;
    assign box.right  = right_reg;
    assign box.top    = top_reg;
    assign box.area   = box_area;

endmodule

// ===== hw/rtl/bfa_overlap.sv =====
// Intersection test and intersection area of one rectangle against the box.
module bfa_overlap (
    input  bfa_pkg::box_t   box,
    input  bfa_pkg::req_t   rect,
    output bfa_pkg::ovl_t   ovl
);

    bfa_pkg::coord_t lo_x, lo_y, hi_x, hi_y;
    logic            hit;

    always_comb
    begin
        lo_x = (rect.rect_llx > box.left)   ? rect.rect_llx : box.left;
        lo_y = (rect.rect_lly > box.bottom) ? rect.rect_lly : box.bottom;
        hi_x = (rect.rect_urx < box.right)  ? rect.rect_urx : box.right;
        hi_y = (rect.rect_ury < box.top)    ? rect.rect_ury : box.top;
        // Touching edges and inverted rectangles give no overlap.
        hit  = (lo_x < hi_x) && (lo_y < hi_y);
        ovl.overlaps_box = hit;
        ovl.isect_area   = hit ? bfa_pkg::area_sat(bfa_pkg::coord_t'(hi_x - lo_x),
                                                   bfa_pkg::coord_t'(hi_y - lo_y))
                               : '0;
    end

endmodule

// ===== hw/rtl/box_free_area_after_blockages.sv =====
// An accepted request is held in the input register, then registered in the result register once that can load.
// Throughput: one request per cycle while the output is ready; the input and result registers form a two-entry pipe.
// The path from input register to result register holds one 16x16 multiplier and a subtract.
// A box corner write is seen by the very next request, box area included.
// Reset clears the box registers, the free area and both valid flags.
module box_free_area_after_blockages (
    input  logic                               clk,
    input  logic                               rst_n,
    bfa_req_if.sink                            req,
    bfa_rsp_if.source                          rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bfa_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [bfa_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [bfa_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    bfa_pkg::box_t  box;
    bfa_pkg::ovl_t  ovl;

    // Input register: holds one accepted request until the result register can take it.
    logic           s1_valid_reg;
    bfa_pkg::req_t  s1_req_reg;

    // Result register and the running free area of the current list.
    logic                        s2_valid_reg;
    logic                        s2_ovl_reg;
    logic [bfa_pkg::ID_BITS-1:0] s2_id_reg;
    bfa_pkg::area_t              s2_ovl_area_reg;
    bfa_pkg::area_t              acc_reg, acc_next;
    bfa_pkg::area_t              acc_base;

    logic s2_load;
    logic s1_adv;
    logic req_fire;

    bfa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box     (box)
    );

    bfa_overlap u_ovl (
        .box  (box),
        .rect (s1_req_reg),
        .ovl  (ovl)
    );

    // The result register may load when it is empty or its request leaves this cycle.
    assign s2_load  = !s2_valid_reg || rsp.ready;
    assign s1_adv   = s1_valid_reg && s2_load;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire = req.valid && req.ready;

    // A list start reloads the box area before this rectangle is subtracted;
    // the subtraction saturates at zero.
    always_comb
    begin
        acc_base = s1_req_reg.start_list ? box.area : acc_reg;
        if (ovl.overlaps_box)
        begin
            acc_next = (acc_base > ovl.isect_area) ? acc_base - ovl.isect_area : '0;
        end
        else
        begin
            acc_next = acc_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg.start_list  <= req.start_list;
            s1_req_reg.blockage_id <= req.blockage_id;
            s1_req_reg.rect_llx    <= req.rect_llx;
            s1_req_reg.rect_lly    <= req.rect_lly;
            s1_req_reg.rect_urx    <= req.rect_urx;
            s1_req_reg.rect_ury    <= req.rect_ury;
        end
        if (s1_adv)
        begin
            s2_ovl_reg      <= ovl.overlaps_box;
            s2_id_reg       <= s1_req_reg.blockage_id;
            s2_ovl_area_reg <= ovl.isect_area;
        end
    end

    assign rsp.valid           = s2_valid_reg;
    assign rsp.overlaps_box    = s2_ovl_reg;
    assign rsp.blockage_id_out = s2_id_reg;
    assign rsp.isect_area      = s2_ovl_area_reg;
    // The accumulator always equals the free area after the request in the result register.
    assign rsp.free_area       = acc_reg;

    // A shown result without overlap carries no area.
    a_no_ovl_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.overlaps_box) |-> (rsp.isect_area == '0))
        else $error("overlap area set without overlap");

    // A strict overlap always has a nonzero area.
    a_ovl_nonzero_area: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.overlaps_box) |-> (rsp.isect_area != '0))
        else $error("overlap reported with zero area");

    // Without a list start and without overlap the free area is unchanged.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_req_reg.start_list && !ovl.overlaps_box) |=> $stable(acc_reg))
        else $error("free area changed without cause");

    // The input side stalls only when both pipeline registers are full and the output waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && rsp.valid && !rsp.ready))
        else $error("request stalled with room in the pipe");

endmodule
